// ===== design/ssgr_pkg.sv =====
// Shared constants, state type and small helper functions for the step
// sequencer with gate ramp. No dependencies; used by every design file.
package ssgr_pkg;

    localparam int NUM_STEPS   = 16;
    localparam int PATTERN_W   = 16;
    localparam int CNT_W       = 32;
    localparam int LEN_W       = 37;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = $clog2(NUM_STEPS);
    localparam int GAP_W       = $clog2(NUM_STEPS + 1);
    localparam int MUL_W       = $clog2(NUM_STEPS + 2);
    localparam int PROD_W      = CNT_W + MUL_W;
    localparam int WIDE_W      = (PROD_W > LEN_W) ? PROD_W : LEN_W;
    localparam int OUT_STEP_W  = 4;
    localparam int OUT_GAP_W   = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ARMED_PATTERN = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } ssgr_state_t;

    // steps numbered 16 and above are never armed
    function automatic logic is_armed(input logic [PATTERN_W-1:0] pattern,
                                      input logic [STEP_W-1:0] s);
        logic [STEP_W+4:0] w;
        w = (STEP_W + 5)'(s);
        if (w >= (STEP_W + 5)'(PATTERN_W))
            return 1'b0;
        return pattern[w[3:0]];
    endfunction

    function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
        logic [STEP_W:0] w;
        w = (STEP_W + 1)'(s) + (STEP_W + 1)'(1);
        if (w == (STEP_W + 1)'(NUM_STEPS))
            return '0;
        return w[STEP_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [PROD_W-1:0] p);
        logic [WIDE_W-1:0] w;
        logic [WIDE_W-1:0] lim;
        w   = WIDE_W'(p);
        lim = WIDE_W'({LEN_W{1'b1}});
        if (w > lim)
            return {LEN_W{1'b1}};
        return w[LEN_W-1:0];
    endfunction

    function automatic logic [OUT_STEP_W-1:0] out_step(input logic [STEP_W-1:0] s);
        logic [STEP_W+OUT_STEP_W-1:0] w;
        w = (STEP_W + OUT_STEP_W)'(s);
        return w[OUT_STEP_W-1:0];
    endfunction

    function automatic logic [OUT_GAP_W-1:0] out_gap(input logic [GAP_W-1:0] g);
        logic [GAP_W+OUT_GAP_W-1:0] w;
        w = (GAP_W + OUT_GAP_W)'(g);
        if (w > (GAP_W + OUT_GAP_W)'({OUT_GAP_W{1'b1}}))
            return {OUT_GAP_W{1'b1}};
        return w[OUT_GAP_W-1:0];
    endfunction

endpackage

// ===== design/step_sequencer_with_gate_ramp.sv =====
// Top level of the step sequencer with gate ramp: APB register, tick
// counters, next-armed-step scan and sequencing of ssgr_mul and ssgr_div.
// Depends on ssgr_pkg, ssgr_mul, ssgr_div.
//
//  channel   | signals                           | direction
//  ----------+-----------------------------------+----------
//  tick in   | s_axis_tvalid/tready/tdata[7:0]   | in
//  result    | m_axis_tvalid/tready/tdata[31:0]  | out
//  config    | psel/penable/pwrite/paddr/pwdata  | in, prdata out
//
// A tick without a trigger is accepted, launches the divider, runs the
// one-bit-per-cycle divider and goes to the output register. A zero
// length or a ramp already past full scale skips the divider loop.
// A trigger adds the next-armed-step scan (one step per cycle, up to 16)
// and the serial multiplier ahead of the divider launch.
// Reset clears all control state and counters; no clearing pass.
// A stalled result sits in the output register; the next tick is accepted
// meanwhile and its result waits in the divider until the register frees.
module step_sequencer_with_gate_ramp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] advance, [1] restart, [7:2] zero
    input  logic [ssgr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] trigger_pulse, [4:1] step_index, [9:5] gap_steps,
    // [25:10] ramp_fraction, [31:26] zero
    output logic [ssgr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssgr_pkg::PADDR_W-1:0]       paddr,
    input  logic [ssgr_pkg::PDATA_W-1:0]       pwdata,
    output logic [ssgr_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import ssgr_pkg::*;

    ssgr_state_t          state_reg, state_next;
    logic [PATTERN_W-1:0] pattern_reg;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [STEP_W-1:0]    probe_reg, probe_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;
    logic [GAP_W-1:0]     last_gap_reg, last_gap_next;
    logic [CNT_W-1:0]     tss_reg, tss_next;
    logic [CNT_W-1:0]     interval_reg, interval_next;
    logic [CNT_W-1:0]     tst_reg, tst_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 trig_reg, trig_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 in_xfer;
    logic                 out_load;
    logic                 cfg_wr;
    logic [CNT_W-1:0]     tss_inc;
    logic [CNT_W-1:0]     tst_inc;
    logic [STEP_W-1:0]    landed;
    logic                 mul_start, mul_done;
    logic [PROD_W-1:0]    mul_prod;
    logic                 div_start, div_done;
    logic [FRAC_W-1:0]    div_q;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_ARMED_PATTERN: prdata = PDATA_W'(pattern_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pattern_reg <= '0;
        else if (cfg_wr && paddr[2] == REG_ARMED_PATTERN)
            pattern_reg <= pwdata[PATTERN_W-1:0];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign tss_inc = (tss_reg == '1) ? tss_reg : tss_reg + CNT_W'(1);
    assign tst_inc = (tst_reg == '1) ? tst_reg : tst_reg + CNT_W'(1);
    assign landed  = s_axis_tdata[1] ? '0 : next_step(step_reg);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        probe_next    = probe_reg;
        gap_next      = gap_reg;
        last_gap_next = last_gap_reg;
        tss_next      = tss_reg;
        interval_next = interval_reg;
        tst_next      = tst_reg;
        len_next      = len_reg;
        trig_next     = trig_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    tst_next   = tst_inc;
                    tss_next   = tss_inc;
                    trig_next  = 1'b0;
                    state_next = ST_DIV_GO;
                    if (s_axis_tdata[1] || s_axis_tdata[0])
                    begin
                        step_next = landed;
                        // restart leaves the interval measurement alone
                        if (!s_axis_tdata[1])
                        begin
                            interval_next = tss_inc;
                            tss_next      = '0;
                        end
                        if (is_armed(pattern_reg, landed))
                        begin
                            trig_next  = 1'b1;
                            gap_next   = GAP_W'(1);
                            probe_next = next_step(landed);
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (gap_reg == GAP_W'(NUM_STEPS) || is_armed(pattern_reg, probe_reg))
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    gap_next   = gap_reg + GAP_W'(1);
                    probe_next = next_step(probe_reg);
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    len_next      = sat_len(mul_prod);
                    last_gap_next = gap_reg;
                    tst_next      = '0;
                    state_next    = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({div_q, out_gap(last_gap_reg),
                                                 out_step(step_reg), trig_reg});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            probe_reg    <= '0;
            gap_reg      <= '0;
            last_gap_reg <= '0;
            tss_reg      <= '0;
            interval_reg <= '0;
            tst_reg      <= '0;
            len_reg      <= '0;
            trig_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            probe_reg    <= probe_next;
            gap_reg      <= gap_next;
            last_gap_reg <= last_gap_next;
            tss_reg      <= tss_next;
            interval_reg <= interval_next;
            tst_reg      <= tst_next;
            len_reg      <= len_next;
            trig_reg     <= trig_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    ssgr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (interval_reg),
        .mplier  (MUL_W'(gap_reg) + MUL_W'(1)),
        .done    (mul_done),
        .product (mul_prod)
    );

    ssgr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ticks    (tst_reg),
        .length   (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // a fresh trigger has zero elapsed ticks, so the ramp starts at nought unless the length is zero
    a_trig_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && trig_reg) |-> (div_q == '0 || len_reg == '0))
        else $error("trigger result with non-zero ramp fraction");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its wait state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            (gap_reg <= GAP_W'(NUM_STEPS) && gap_reg != '0 &&
             (STEP_W + 1)'(probe_reg) < (STEP_W + 1)'(NUM_STEPS)))
        else $error("step scan out of range");

endmodule

// ===== design/ssgr_mul.sv =====
// Bit-serial shift-and-add multiplier: interval times (gap + 1),
// one multiplier bit per cycle. Depends on ssgr_pkg.
module ssgr_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ssgr_pkg::CNT_W-1:0]  mcand,
    input  logic [ssgr_pkg::MUL_W-1:0]  mplier,
    output logic                       done,
    output logic [ssgr_pkg::PROD_W-1:0] product
);
    import ssgr_pkg::*;

    localparam int CW = $clog2(MUL_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MUL_W-1:0]  mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CW'(MUL_W);
            acc_next    = '0;
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== design/ssgr_div.sv =====
// Restoring divider for the ramp fraction: (ticks << 16) / length,
// one quotient bit per cycle, clamped to full scale. Depends on ssgr_pkg.
module ssgr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ssgr_pkg::CNT_W-1:0]  ticks,
    input  logic [ssgr_pkg::LEN_W-1:0]  length,
    output logic                       done,
    output logic [ssgr_pkg::FRAC_W-1:0] quotient
);
    import ssgr_pkg::*;

    localparam int CW = $clog2(FRAC_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [FRAC_W-1:0] q_reg, q_next;
    logic [LEN_W:0]    rem_sh;
    logic [LEN_W:0]    rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        q_next    = q_reg;
        rem_sh    = {rem_reg, 1'b0};
        rem_sub   = rem_sh - {1'b0, len_reg};
        if (start)
        begin
            len_next = length;
            rem_next = LEN_W'(ticks);
            cnt_next = CW'(FRAC_W);
            // zero length, or ticks already past the length: full scale
            if (length == '0 || LEN_W'(ticks) >= length)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                q_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, len_reg})
            begin
                rem_next = rem_sub[LEN_W-1:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[LEN_W-1:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        len_reg <= len_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== tb/sv/step_sequencer_with_gate_ramp_test.sv =====
// Self-checking testbench for step_sequencer_with_gate_ramp: tick transfers in,
// one result per tick out, checked against an in-bench sequencer predictor.
// Depends on ssgr_pkg and the step_sequencer_with_gate_ramp RTL.
module step_sequencer_with_gate_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_TICKS = 200;
    localparam int NUM_PHASES  = 6;
    localparam logic [ssgr_pkg::PADDR_W-1:0] PATTERN_ADDR =
        ssgr_pkg::PADDR_W'({ssgr_pkg::REG_ARMED_PATTERN, 2'b00});
    localparam logic [ssgr_pkg::LEN_W-1:0] LEN_SAT = {ssgr_pkg::LEN_W{1'b1}};

    typedef struct {
        logic advance;
        logic restart;
    } tick_t;

    typedef struct {
        logic        trigger;
        logic [3:0]  step;
        logic [4:0]  gap;
        logic [15:0] fraction;
    } gate_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // [0] advance, [1] restart, [7:2] zero
    logic [ssgr_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [0] trigger_pulse, [4:1] step_index, [9:5] gap_steps, [25:10] ramp_fraction
    logic [ssgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ssgr_pkg::PADDR_W-1:0] paddr = '0;
    logic [ssgr_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ssgr_pkg::PDATA_W-1:0] prdata;
    logic pready;

    step_sequencer_with_gate_ramp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    logic [15:0]                   armed_pattern = '0;
    int unsigned                   seq_step = 0;
    logic [ssgr_pkg::CNT_W-1:0]    since_step = '0;
    logic [ssgr_pkg::CNT_W-1:0]    step_interval = '0;
    logic [ssgr_pkg::CNT_W-1:0]    since_trigger = '0;
    logic [ssgr_pkg::LEN_W-1:0]    ramp_len = '0;
    int unsigned                   gap_found = 0;

    tick_t        tick_queue[$];
    gate_result_t expected_results[$];
    tick_t        next_tick;
    gate_result_t oldest;
    gate_result_t predicted;
    logic         in_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    function automatic logic step_armed(input int unsigned s);
        return (s < 16) && armed_pattern[s[3:0]];
    endfunction

    // lands on seq_step; returns 1 when the step fires
    function automatic logic land_on_step();
        int unsigned gap;
        logic [63:0] len;
        gap = 1;
        if (!step_armed(seq_step))
            return 1'b0;
        while (gap < ssgr_pkg::NUM_STEPS &&
               !step_armed((seq_step + gap) % ssgr_pkg::NUM_STEPS))
            gap++;
        len = 64'(step_interval) * 64'(gap + 1);
        ramp_len = (len > 64'(LEN_SAT)) ? LEN_SAT : len[ssgr_pkg::LEN_W-1:0];
        gap_found = gap;
        since_trigger = '0;
        return 1'b1;
    endfunction

    function automatic gate_result_t sequencer_tick(input logic adv, input logic rst);
        gate_result_t r;
        logic [63:0]  quot;
        r.trigger = 1'b0;
        if (since_step != '1)
            since_step++;
        if (since_trigger != '1)
            since_trigger++;
        if (rst)
        begin
            seq_step = 0;
            r.trigger = land_on_step();
        end
        else if (adv)
        begin
            seq_step = (seq_step + 1) % ssgr_pkg::NUM_STEPS;
            step_interval = since_step;
            since_step = '0;
            r.trigger = land_on_step();
        end
        if (ramp_len == '0)
            r.fraction = 16'hFFFF;
        else
        begin
            quot = {16'h0, since_trigger, 16'h0} / 64'(ramp_len);
            r.fraction = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
        end
        r.step = seq_step[3:0];
        r.gap = (gap_found > 31) ? 5'd31 : gap_found[4:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic push_tick(input logic adv, input logic rst, inout int count);
        tick_t t;
        t.advance = adv;
        t.restart = rst;
        tick_queue.insert(tick_queue.size(), t);
        count++;
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pattern(input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= PATTERN_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        armed_pattern = value;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // tick driver and ready generator
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_tick = tick_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, next_tick.restart, next_tick.advance};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predictor on accepted ticks, checker on accepted results
    always @(posedge clk)
    begin
        cycle_count++;
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            predicted = sequencer_tick(s_axis_tdata[0], s_axis_tdata[1]);
            expected_results.insert(expected_results.size(), predicted);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none actual %0h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                check_field("trigger_pulse", 32'(oldest.trigger), 32'(m_axis_tdata[0]));
                check_field("step_index", 32'(oldest.step), 32'(m_axis_tdata[4:1]));
                check_field("gap_steps", 32'(oldest.gap), 32'(m_axis_tdata[9:5]));
                check_field("ramp_fraction", 32'(oldest.fraction),
                            32'(m_axis_tdata[25:10]));
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int n;
        int k;
        int reps;
        bit paused;
        logic [15:0] phase_pattern;
        n = 0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: steps 0 and 15 armed
        write_pattern(16'h8001);
        push_tick(1'b0, 1'b1, n);             // restart before any advance: zero-length ramp
        push_tick(1'b0, 1'b0, n);
        push_tick(1'b0, 1'b0, n);
        push_tick(1'b1, 1'b1, n);             // restart wins over advance
        push_tick(1'b1, 1'b0, n);
        push_tick(1'b0, 1'b0, n);
        repeat (13) push_tick(1'b1, 1'b0, n);
        push_tick(1'b1, 1'b0, n);             // lands on 15, next armed one step on
        push_tick(1'b0, 1'b0, n);
        push_tick(1'b0, 1'b0, n);
        push_tick(1'b1, 1'b0, n);             // wraps to step 0
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_pattern = 16'h0000;
                1: phase_pattern = 16'hFFFF;
                2: phase_pattern = 16'h0040;  // lone armed step: full-circle gap
                4: phase_pattern = 16'h8000;
                default: phase_pattern = 16'($urandom_range(0, 65535));
            endcase
            write_pattern(phase_pattern);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase
            n = 0;
            while (n < PHASE_TICKS)
            begin
                if ($urandom_range(3) != 0)
                begin
                    // regular clock of advances, occasionally cut by a restart
                    k = $urandom_range(1, ($urandom_range(4) == 0) ? 40 : 6);
                    reps = $urandom_range(1, (k > 6) ? 3 : 20);
                    repeat (reps)
                    begin
                        repeat (k - 1) push_tick(1'b0, 1'b0, n);
                        push_tick(1'b1, 1'b0, n);
                    end
                    if ($urandom_range(4) == 0)
                        push_tick(1'($urandom_range(1)), 1'b1, n);
                end
                else
                begin
                    repeat ($urandom_range(1, 10))
                        push_tick($urandom_range(99) < 30, $urandom_range(99) < 20, n);
                end
                if (p == 2 && !paused && n >= PHASE_TICKS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
